[design/rrq_pkg.sv]
`default_nettype none

package rrq_pkg;

  localparam int NUM_TASKS  = 64;
  localparam int TOP_LEVEL  = 7;
  localparam int NUM_LEVELS = TOP_LEVEL + 1;
  localparam int TID_W      = $clog2(NUM_TASKS);
  localparam int LIDX_W     = $clog2(NUM_LEVELS);
  localparam int CNT_W      = $clog2(NUM_TASKS + 1);
  localparam int LVL_W      = 3;
  localparam int FUNC_W     = 3;
  localparam int SLICE_W    = 32;
  localparam int OCNT_W     = 7;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 48;
  localparam int IN_PAD_W   = IN_W - (FUNC_W + TID_W + LVL_W + SLICE_W);

  typedef logic [TID_W-1:0]   tid_t;
  typedef logic [LIDX_W-1:0]  lidx_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SLICE_W-1:0] slice_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ = 3'd0,
    FUNC_DEQ = 3'd1,
    FUNC_DET = 3'd2,
    FUNC_LEN = 3'd3,
    FUNC_PRE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DUP   = 2'd2
  } status_e;

  // input word, last field in the lowest bits
  typedef struct packed {
    logic [IN_PAD_W-1:0] pad;
    slice_t              slice_in;
    lvl_t                level;
    tid_t                task_id;
    logic [FUNC_W-1:0]   func;
  } in_word_t;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic              preempt;
    logic [OCNT_W-1:0] level_count;
    slice_t            picked_slice;
    tid_t              picked_id;
    status_e           status;
  } res_word_t;

  typedef struct packed {
    logic we;
    tid_t addr;
    tid_t data;
  } link_wr_t;

  typedef struct packed {
    logic   we;
    tid_t   addr;
    lidx_t  lvl;
    slice_t slice;
  } ent_wr_t;

  typedef struct packed {
    logic  found;
    lidx_t idx;
  } pick_t;

  // highest non-empty level
  function automatic pick_t top_find(input logic [NUM_LEVELS-1:0] nz);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nz[i]) begin
        p.found = 1'b1;
        p.idx   = LIDX_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[design/priority_round_robin_ready_queue.sv]
`default_nettype none

// Multilevel priority FIFO ready queue for up to 64 task ids over 8 levels (7 highest).
// Each word carries one command: enqueue, dequeue, detach, length query or preempt
// check, and gives exactly one result word. The block takes a new word every cycle
// while the output is not stalled. A word first reads the link, level and slice
// memories, then updates the lists and loads the output register. A write made by one
// word is forwarded to the memory read of the next.
// Nothing needs clearing after reset, so words are accepted right away.
module priority_round_robin_ready_queue
  import rrq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // func[2:0], task_id[8:3], level[11:9], slice_in[43:12], zero pad[47:44]
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // status[1:0], picked_id[7:2], picked_slice[39:8], level_count[46:40], preempt[47]
  output logic [OUT_W-1:0]      m_axis_tdata
);

  in_word_t  in_word;
  in_word_t  op_q;
  logic      op_valid_q;
  res_word_t res_d;
  res_word_t res_q;
  logic      res_valid_q;
  logic      accept;
  logic      fire;
  link_wr_t  next_wr;
  link_wr_t  prev_wr;
  ent_wr_t   ent_wr;
  tid_t      dq_addr;
  tid_t      next_raddr;
  tid_t      next_ram;
  tid_t      prev_ram;
  lidx_t     lvl_ram;
  slice_t    slice_ram;
  logic      next_hit_q;
  logic      prev_hit_q;
  logic      lvl_hit_q;
  logic      slice_hit_q;
  tid_t      next_byp_q;
  tid_t      prev_byp_q;
  lidx_t     lvl_byp_q;
  slice_t    slice_byp_q;
  tid_t      next_rd;
  tid_t      prev_rd;
  lidx_t     lvl_rd;
  slice_t    slice_rd;

  assign in_word       = in_word_t'(s_axis_tdata);
  assign fire          = op_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !op_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign next_raddr    = (in_word.func == FUNC_DEQ) ? dq_addr : in_word.task_id;

  assign next_rd  = next_hit_q  ? next_byp_q  : next_ram;
  assign prev_rd  = prev_hit_q  ? prev_byp_q  : prev_ram;
  assign lvl_rd   = lvl_hit_q   ? lvl_byp_q   : lvl_ram;
  assign slice_rd = slice_hit_q ? slice_byp_q : slice_ram;

  rrq_ram #(.DEPTH(NUM_TASKS), .WIDTH(TID_W)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_wr.we),
    .waddr_i (next_wr.addr),
    .wdata_i (next_wr.data),
    .re_i    (accept),
    .raddr_i (next_raddr),
    .rdata_o (next_ram)
  );

  rrq_ram #(.DEPTH(NUM_TASKS), .WIDTH(TID_W)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_wr.we),
    .waddr_i (prev_wr.addr),
    .wdata_i (prev_wr.data),
    .re_i    (accept),
    .raddr_i (in_word.task_id),
    .rdata_o (prev_ram)
  );

  rrq_ram #(.DEPTH(NUM_TASKS), .WIDTH(LIDX_W)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (ent_wr.we),
    .waddr_i (ent_wr.addr),
    .wdata_i (ent_wr.lvl),
    .re_i    (accept),
    .raddr_i (in_word.task_id),
    .rdata_o (lvl_ram)
  );

  rrq_ram #(.DEPTH(NUM_TASKS), .WIDTH(SLICE_W)) u_slice_ram (
    .clk_i   (clk_i),
    .we_i    (ent_wr.we),
    .waddr_i (ent_wr.addr),
    .wdata_i (ent_wr.slice),
    .re_i    (accept),
    .raddr_i (dq_addr),
    .rdata_o (slice_ram)
  );

  rrq_exec u_exec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .op_i       (op_q),
    .next_rd_i  (next_rd),
    .prev_rd_i  (prev_rd),
    .lvl_rd_i   (lvl_rd),
    .slice_rd_i (slice_rd),
    .res_o      (res_d),
    .next_wr_o  (next_wr),
    .prev_wr_o  (prev_wr),
    .ent_wr_o   (ent_wr),
    .dq_addr_o  (dq_addr)
  );

  // read-during-write forwarding
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= in_word;
      next_hit_q  <= next_wr.we && (next_wr.addr == next_raddr);
      prev_hit_q  <= prev_wr.we && (prev_wr.addr == in_word.task_id);
      lvl_hit_q   <= ent_wr.we && (ent_wr.addr == in_word.task_id);
      slice_hit_q <= ent_wr.we && (ent_wr.addr == dq_addr);
      next_byp_q  <= next_wr.data;
      prev_byp_q  <= prev_wr.data;
      lvl_byp_q   <= ent_wr.lvl;
      slice_byp_q <= ent_wr.slice;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        op_valid_q <= 1'b1;
      end else if (fire) begin
        op_valid_q <= 1'b0;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q;

endmodule

`default_nettype wire

[design/rrq_ram.sv]
`default_nettype none

module rrq_ram
  import rrq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/rrq_exec.sv]
`default_nettype none

module rrq_exec
  import rrq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire in_word_t  op_i,
  input  wire tid_t      next_rd_i,
  input  wire tid_t      prev_rd_i,
  input  wire lidx_t     lvl_rd_i,
  input  wire slice_t    slice_rd_i,
  output res_word_t      res_o,
  output link_wr_t       next_wr_o,
  output link_wr_t       prev_wr_o,
  output ent_wr_t        ent_wr_o,
  output tid_t           dq_addr_o
);

  cnt_t                  count_q [NUM_LEVELS];
  cnt_t                  count_d [NUM_LEVELS];
  tid_t                  head_q  [NUM_LEVELS];
  tid_t                  head_d  [NUM_LEVELS];
  tid_t                  tail_q  [NUM_LEVELS];
  tid_t                  tail_d  [NUM_LEVELS];
  logic [NUM_TASKS-1:0]  queued_q;
  logic [NUM_TASKS-1:0]  queued_d;
  logic [NUM_LEVELS-1:0] nz_q;
  logic [NUM_LEVELS-1:0] nz_d;
  pick_t                 pick_q;
  pick_t                 pick_d;
  logic                  ul_en;
  tid_t                  ul_t;
  lidx_t                 ul_lv;
  lidx_t                 enq_lv;

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nz_q[i] = (count_q[i] != '0);
    end
    pick_q = top_find(nz_q);
    enq_lv = (op_i.level > LVL_W'(TOP_LEVEL)) ? LIDX_W'(TOP_LEVEL) : LIDX_W'(op_i.level);

    count_d   = count_q;
    head_d    = head_q;
    tail_d    = tail_q;
    queued_d  = queued_q;
    next_wr_o = '0;
    prev_wr_o = '0;
    ent_wr_o  = '0;
    res_o     = '0;
    ul_en     = 1'b0;
    ul_t      = '0;
    ul_lv     = '0;

    if (fire_i) begin
      case (op_i.func)
        FUNC_ENQ: begin
          if (queued_q[op_i.task_id]) begin
            res_o.status = ST_DUP;
          end else begin
            ent_wr_o = '{we: 1'b1, addr: op_i.task_id, lvl: enq_lv, slice: op_i.slice_in};
            if (count_q[enq_lv] == '0) begin
              head_d[enq_lv] = op_i.task_id;
            end else begin
              next_wr_o = '{we: 1'b1, addr: tail_q[enq_lv], data: op_i.task_id};
              prev_wr_o = '{we: 1'b1, addr: op_i.task_id, data: tail_q[enq_lv]};
            end
            tail_d[enq_lv]            = op_i.task_id;
            count_d[enq_lv]           = count_q[enq_lv] + CNT_W'(1);
            queued_d[op_i.task_id]    = 1'b1;
          end
        end
        FUNC_DEQ: begin
          if (!pick_q.found) begin
            res_o.status = ST_EMPTY;
          end else begin
            res_o.picked_id    = head_q[pick_q.idx];
            res_o.picked_slice = slice_rd_i;
            ul_en              = 1'b1;
            ul_t               = head_q[pick_q.idx];
            ul_lv              = pick_q.idx;
          end
        end
        FUNC_DET: begin
          if (queued_q[op_i.task_id]) begin
            ul_en = 1'b1;
            ul_t  = op_i.task_id;
            ul_lv = lvl_rd_i;
          end
        end
        FUNC_LEN: begin
          if (op_i.level <= LVL_W'(TOP_LEVEL)) begin
            res_o.level_count = OCNT_W'(count_q[LIDX_W'(op_i.level)]);
          end
        end
        FUNC_PRE: begin
          for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i > int'(op_i.level) && nz_q[i]) begin
              res_o.preempt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // unlink from its level's list
    if (ul_en) begin
      if (count_q[ul_lv] <= CNT_W'(1)) begin
        count_d[ul_lv] = '0;
      end else begin
        if (head_q[ul_lv] == ul_t) begin
          head_d[ul_lv] = next_rd_i;
        end else begin
          next_wr_o = '{we: 1'b1, addr: prev_rd_i, data: next_rd_i};
        end
        if (tail_q[ul_lv] == ul_t) begin
          tail_d[ul_lv] = prev_rd_i;
        end else begin
          prev_wr_o = '{we: 1'b1, addr: next_rd_i, data: prev_rd_i};
        end
        count_d[ul_lv] = count_q[ul_lv] - CNT_W'(1);
      end
      queued_d[ul_t] = 1'b0;
    end

    // head that the next dequeue will read
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nz_d[i] = (count_d[i] != '0);
    end
    pick_d    = top_find(nz_d);
    dq_addr_o = head_d[pick_d.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        count_q[i] <= '0;
      end
      queued_q <= '0;
    end else if (fire_i) begin
      count_q  <= count_d;
      queued_q <= queued_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

`default_nettype wire

[design/rrq_checker.sv]
`default_nettype none

module rrq_checker
  import rrq_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [IN_W-1:0]  s_axis_tdata,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  res_word_t res;
  logic      s_acc;

  assign res   = res_word_t'(m_axis_tdata);
  assign s_acc = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.status == ST_OK || res.status == ST_EMPTY || res.status == ST_DUP)
    else $error("unknown status code");

  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == ST_EMPTY |->
      res.picked_id == '0 && res.picked_slice == '0 && res.level_count == '0 && !res.preempt)
    else $error("empty dequeue carries data");

  // word taken with idle output is followed by a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("result missing after accepted word");

endmodule

bind priority_round_robin_ready_queue rrq_checker u_rrq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
